// ===== src/mmm_pkg.sv =====
// ----------------------------------------------------------------------------
// mmm_pkg: shared types and constants of the matrix multiply unit
// Carries the element tap that moves along the cell chain, the controller
// states, the configuration register indexes and the saturation limits.
// ----------------------------------------------------------------------------
`default_nettype none

package mmm_pkg;

	// widths fixed by the element and configuration formats
	localparam int ELEM_W = 32;
	localparam int DIM_W  = 4;
	localparam int IDX_W  = 3;
	localparam int CFG_IW = 2;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_COLS_B    = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// saturation limits of a Q16.16 element
	localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

	// one A element travelling along the chain with its inner index
	typedef struct packed {
		logic              vld;
		logic              first;
		logic [IDX_W-1:0]  k;
		logic [ELEM_W-1:0] a;
	} tap_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// zero reads as one, anything above the limit as the limit
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxd);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > maxd) begin
			r = DIM_W'(maxd);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/matrix_matrix_multiply_unit.sv =====
// Loading: one element item per cycle; items causing no result need no more.
// After the last B item the product is computed one row of C at a time: the
// MAC cell chain is filled, drained and read out one column per cycle while
// out_stall is low. Input is stalled while the product is computed; results
// leave one per cycle unless the output stalls.
// Reset: dimensions return to 8, load count to zero; stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_matrix_multiply_unit: Q16.16 matrix product on a chain of MAC cells
// A is kept in a memory, B is spread column-wise over the cells; A elements
// stream along the chain and each cell accumulates one product column.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_matrix_multiply_unit #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mmm_pkg::CFG_IW-1:0]        cfg_index,
	input  wire logic [mmm_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mmm_pkg::ELEM_W-1:0]        element,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mmm_pkg::ELEM_W-1:0]             product,
	output logic [mmm_pkg::IDX_W-1:0]              row,
	output logic [mmm_pkg::IDX_W-1:0]              col,
	output logic                                   saturated,
	output logic                                   last
);

	localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W = 2 * mmm_pkg::ELEM_W + KW;
	localparam int DRAIN_LEN = MAX_DIM + 2;
	localparam int DCW   = $clog2(DRAIN_LEN + 1);
	localparam int CNT_W = 8;

	logic [mmm_pkg::DIM_W-1:0] rows_a_q, inner_q, cols_q;
	logic [mmm_pkg::DIM_W-1:0] ra, kd, cb;
	logic [CNT_W-1:0] na, total;
	logic [CNT_W-1:0] load_count_q;
	logic [KW-1:0] bk_q, bj_q;
	logic in_fire;
	logic last_item;

	mmm_pkg::state_t state_q, state_d;
	logic [KW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] rbase_q;
	logic [DCW-1:0] drain_q;
	logic k_end, j_end, i_end, drain_end;
	logic emit_fire;

	logic [mmm_pkg::ELEM_W-1:0] a_mem [DEPTH];
	logic [mmm_pkg::ELEM_W-1:0] rd_s1;
	logic vld_s1, first_s1;
	logic [KW-1:0] k_s1;

	mmm_pkg::tap_t taps [MAX_DIM+1];
	logic signed [ACC_W-1:0] accs [MAX_DIM];
	logic signed [ACC_W-1:0] acc_sel;
	logic [mmm_pkg::ELEM_W-1:0] rnd_product;
	logic rnd_sat;

	logic out_valid_q;
	logic [mmm_pkg::ELEM_W-1:0] product_q;
	logic [mmm_pkg::IDX_W-1:0] row_q, col_q;
	logic sat_q, last_q;

	// effective dimensions and item counts
	always_comb begin
		ra    = mmm_pkg::clamp_dim(rows_a_q, MAX_DIM);
		kd    = mmm_pkg::clamp_dim(inner_q, MAX_DIM);
		cb    = mmm_pkg::clamp_dim(cols_q, MAX_DIM);
		na    = CNT_W'(ra) * CNT_W'(kd);
		total = na + CNT_W'(kd) * CNT_W'(cb);
	end

	assign in_stall  = (state_q != mmm_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign last_item = (load_count_q == CNT_W'(total - CNT_W'(1)));

	// configuration registers and load counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= mmm_pkg::DIM_RESET;
			inner_q      <= mmm_pkg::DIM_RESET;
			cols_q       <= mmm_pkg::DIM_RESET;
			load_count_q <= '0;
			bk_q         <= '0;
			bj_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmm_pkg::CFG_ROWS_A: begin
					rows_a_q     <= cfg_data;
					load_count_q <= '0;
				end
				mmm_pkg::CFG_INNER_DIM: begin
					inner_q      <= cfg_data;
					load_count_q <= '0;
				end
				mmm_pkg::CFG_COLS_B: begin
					cols_q       <= cfg_data;
					load_count_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_fire) begin
			load_count_q <= last_item ? '0 : CNT_W'(load_count_q + CNT_W'(1));
			if (load_count_q < na) begin
				bk_q <= '0;
				bj_q <= '0;
			end else if (mmm_pkg::DIM_W'(bj_q) == mmm_pkg::DIM_W'(cb - 4'd1)) begin
				bj_q <= '0;
				bk_q <= KW'(bk_q + KW'(1));
			end else begin
				bj_q <= KW'(bj_q + KW'(1));
			end
		end
	end

	// A memory: written while loading, read at the row base plus the inner index
	always_ff @(posedge clk) begin
		if (in_fire && (load_count_q < na)) begin
			a_mem[load_count_q[AW-1:0]] <= element;
		end
		rd_s1 <= a_mem[AW'(rbase_q + AW'(k_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			k_s1     <= '0;
		end else begin
			vld_s1   <= (state_q == mmm_pkg::ST_FEED);
			first_s1 <= (k_q == '0);
			k_s1     <= k_q;
		end
	end

	// controller
	assign k_end     = (mmm_pkg::DIM_W'(k_q) == mmm_pkg::DIM_W'(kd - 4'd1));
	assign j_end     = (mmm_pkg::DIM_W'(j_q) == mmm_pkg::DIM_W'(cb - 4'd1));
	assign i_end     = (mmm_pkg::DIM_W'(i_q) == mmm_pkg::DIM_W'(ra - 4'd1));
	assign drain_end = (drain_q == DCW'(DRAIN_LEN));
	assign emit_fire = (state_q == mmm_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmm_pkg::ST_IDLE: begin
				if (in_fire && !cfg_we && last_item) begin
					state_d = mmm_pkg::ST_FEED;
				end
			end
			mmm_pkg::ST_FEED: begin
				if (k_end) begin
					state_d = mmm_pkg::ST_DRAIN;
				end
			end
			mmm_pkg::ST_DRAIN: begin
				if (drain_end) begin
					state_d = mmm_pkg::ST_EMIT;
				end
			end
			mmm_pkg::ST_EMIT: begin
				if (emit_fire && j_end) begin
					state_d = i_end ? mmm_pkg::ST_IDLE : mmm_pkg::ST_FEED;
				end
			end
			default: state_d = mmm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row, column, inner and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			rbase_q <= '0;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				mmm_pkg::ST_IDLE: begin
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					rbase_q <= '0;
				end
				mmm_pkg::ST_FEED: begin
					drain_q <= '0;
					k_q     <= k_end ? '0 : KW'(k_q + KW'(1));
				end
				mmm_pkg::ST_DRAIN: begin
					drain_q <= DCW'(drain_q + DCW'(1));
				end
				mmm_pkg::ST_EMIT: begin
					if (emit_fire) begin
						if (j_end) begin
							j_q     <= '0;
							i_q     <= KW'(i_q + KW'(1));
							rbase_q <= AW'(rbase_q + AW'(kd));
						end else begin
							j_q <= KW'(j_q + KW'(1));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// chain of MAC cells
	always_comb begin
		taps[0]       = '0;
		taps[0].vld   = vld_s1;
		taps[0].first = first_s1;
		taps[0].k     = mmm_pkg::IDX_W'(k_s1);
		taps[0].a     = rd_s1;
	end

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		mmm_cell #(
			.MAX_DIM (MAX_DIM),
			.ACC_W   (ACC_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tap_in  (taps[c]),
			.tap_out (taps[c+1]),
			.b_we    (in_fire && !cfg_we && (load_count_q >= na) && (bj_q == KW'(c))),
			.b_k     (mmm_pkg::IDX_W'(bk_q)),
			.b_data  (element),
			.acc     (accs[c])
		);
	end

	// column select and scaling
	assign acc_sel = accs[j_q];

	mmm_round #(
		.ACC_W     (ACC_W),
		.FRAC_BITS (FRAC_BITS)
	) u_round (
		.acc       (acc_sel),
		.product   (rnd_product),
		.saturated (rnd_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			product_q <= rnd_product;
			sat_q     <= rnd_sat;
			row_q     <= mmm_pkg::IDX_W'(i_q);
			col_q     <= mmm_pkg::IDX_W'(j_q);
			last_q    <= i_end && j_end;
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign row       = row_q;
	assign col       = col_q;
	assign saturated = sat_q;
	assign last      = last_q;

	logic unused_tap;
	assign unused_tap = ^taps[MAX_DIM];

endmodule

`default_nettype wire

// ===== src/mmm_cell.sv =====
// ----------------------------------------------------------------------------
// mmm_cell: one multiply-accumulate cell of the chain
// Holds one column of B, multiplies the passing A element by the matching
// B entry and accumulates one product element exactly; forwards the A item.
// ----------------------------------------------------------------------------
`default_nettype none

module mmm_cell #(
	parameter int MAX_DIM = 8,
	parameter int ACC_W   = 67
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mmm_pkg::tap_t                    tap_in,
	output mmm_pkg::tap_t                         tap_out,
	input  wire logic                             b_we,
	input  wire logic [mmm_pkg::IDX_W-1:0]        b_k,
	input  wire logic [mmm_pkg::ELEM_W-1:0]       b_data,
	output logic signed [ACC_W-1:0]               acc
);

	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [mmm_pkg::ELEM_W-1:0] b_q [MAX_DIM];
	mmm_pkg::tap_t              tap_q;
	logic signed [2*mmm_pkg::ELEM_W-1:0] prod_s2;
	logic                       vld_s2;
	logic                       first_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// column of B owned by this cell
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q[b_k[KW-1:0]] <= b_data;
		end
	end

	// hand the A item to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else begin
			tap_q <= tap_in;
		end
	end

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			vld_s2   <= tap_in.vld;
			first_s2 <= tap_in.first;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(tap_in.a) * $signed(b_q[tap_in.k[KW-1:0]]);
	end

	// exact accumulation, restarted on the first term of a dot product
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign tap_out = tap_q;
	assign acc     = acc_q;

endmodule

`default_nettype wire

// ===== src/mmm_round.sv =====
// ----------------------------------------------------------------------------
// mmm_round: fixed-point scaling and saturation of a dot product
// Shifts the wide sum right arithmetically by the fraction width and clamps
// it to the 32-bit element range, flagging any clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module mmm_round #(
	parameter int ACC_W     = 67,
	parameter int FRAC_BITS = 16
) (
	input  wire logic signed [ACC_W-1:0]          acc,
	output logic [mmm_pkg::ELEM_W-1:0]            product,
	output logic                                  saturated
);

	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-mmm_pkg::ELEM_W:0] top;
	logic fits;

	// floor shift, then check that the upper bits are all sign copies
	always_comb begin
		shifted   = acc >>> FRAC_BITS;
		top       = shifted[ACC_W-1:mmm_pkg::ELEM_W-1];
		fits      = (&top) || (~|top);
		saturated = !fits;
		if (fits) begin
			product = shifted[mmm_pkg::ELEM_W-1:0];
		end else if (acc[ACC_W-1]) begin
			product = mmm_pkg::Q_MIN;
		end else begin
			product = mmm_pkg::Q_MAX;
		end
	end

endmodule

`default_nettype wire
